// File: rtl/agpg_pkg.sv
// ----------------------------------------------------------------------------
// agpg_pkg - shared constants for the ATR-gated price gap detector
// Price widths, ATR window size, derived counter and sum widths, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package agpg_pkg;

	// price path and ATR window
	localparam int PRICE_BITS = 32;
	localparam int ATR_LEN    = 14;
	localparam int CNT_BITS   = 24;
	localparam int Q_BITS     = 16;
	localparam int Q_FRAC     = 8;

	// derived widths
	localparam int HELD_BITS = $clog2(ATR_LEN + 1);
	localparam int PTR_BITS  = (ATR_LEN > 1) ? $clog2(ATR_LEN) : 1;
	localparam int SUM_BITS  = PRICE_BITS + ((ATR_LEN > 1) ? $clog2(ATR_LEN) : 0);
	localparam int LHS_BITS  = PRICE_BITS + HELD_BITS;
	localparam int CMP_BITS  = Q_BITS + SUM_BITS;

	// configuration port
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;
	localparam logic REG_MIN_GAP = 1'b0;
	localparam logic REG_MAX_GAP = 1'b1;
	localparam logic [Q_BITS-1:0] MIN_GAP_RESET = 16'd13;
	localparam logic [Q_BITS-1:0] MAX_GAP_RESET = 16'd1536;

endpackage

`default_nettype wire

// File: rtl/atr_gated_price_gap_detector.sv
// ----------------------------------------------------------------------------
// atr_gated_price_gap_detector - three-bar price gap finder gated by ATR
// Keeps the last bars and a ring of true ranges, reports gaps whose size lies
// between configured Q8.8 multiples of the average true range.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  bar       in         bar_valid / bar_stall  bar_high, bar_low, bar_close
//  gap       out        gap_valid / gap_stall  gap_down, gap_bottom, gap_top, bar_number
//  cfg       in         apb psel / penable     paddr, pwdata, prdata
//
//  one bar is taken every cycle while bar_stall is low; a result for its bar
//  passes through each stage register into the result register on the gap port
//  stages: input/state snapshot, true range and gap edges, ring and range sum
//  update, cross multiplies, compare into the result register
//  a stall on gap freezes only full stages, empty ones keep filling
//  arst_n clears all control state and loads the default gate multiples
//
`default_nettype none

module atr_gated_price_gap_detector (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// bar channel
	input  wire logic                                bar_valid,
	output logic                                     bar_stall,
	input  wire logic [agpg_pkg::PRICE_BITS-1:0]     bar_high,
	input  wire logic [agpg_pkg::PRICE_BITS-1:0]     bar_low,
	input  wire logic [agpg_pkg::PRICE_BITS-1:0]     bar_close,
	// gap channel
	output logic                                     gap_valid,
	input  wire logic                                gap_stall,
	output logic                                     gap_down,
	output logic [agpg_pkg::PRICE_BITS-1:0]          gap_bottom,
	output logic [agpg_pkg::PRICE_BITS-1:0]          gap_top,
	output logic [agpg_pkg::CNT_BITS-1:0]            bar_number,
	// configuration
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [agpg_pkg::ADDR_BITS-1:0]      paddr,
	input  wire logic [agpg_pkg::DATA_BITS-1:0]      pwdata,
	output logic [agpg_pkg::DATA_BITS-1:0]           prdata,
	output logic                                     pready
);

	localparam int P  = agpg_pkg::PRICE_BITS;
	localparam int HB = agpg_pkg::HELD_BITS;
	localparam int PB = agpg_pkg::PTR_BITS;
	localparam int SB = agpg_pkg::SUM_BITS;
	localparam int LB = agpg_pkg::LHS_BITS;
	localparam int CB = agpg_pkg::CMP_BITS;
	localparam int QB = agpg_pkg::Q_BITS;
	localparam int NB = agpg_pkg::CNT_BITS;

	// configuration registers
	logic [QB-1:0] min_gap_q, max_gap_q;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q <= agpg_pkg::MIN_GAP_RESET;
			max_gap_q <= agpg_pkg::MAX_GAP_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == agpg_pkg::REG_MIN_GAP) min_gap_q <= pwdata[QB-1:0];
			else max_gap_q <= pwdata[QB-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == agpg_pkg::REG_MIN_GAP) prdata = {{(32-QB){1'b0}}, min_gap_q};
		else prdata = {{(32-QB){1'b0}}, max_gap_q};
	end

	// stage occupancy and ready chain
	logic v_s1, v_s2, v_s3, v_s4, res_v_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic accept;

	assign rdy5      = !res_v_q || !gap_stall;
	assign rdy4      = !v_s4 || rdy5;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign bar_stall = !rdy1;
	assign accept    = bar_valid && rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= bar_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// bar history, updated at accept
	logic [P-1:0]  older_high_q, older_low_q, prior_high_q, prior_low_q, prior_close_q;
	logic [1:0]    bars_seen_q;
	logic [NB-1:0] bar_counter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_high_q  <= '0;
			older_low_q   <= '0;
			prior_high_q  <= '0;
			prior_low_q   <= '0;
			prior_close_q <= '0;
			bars_seen_q   <= '0;
			bar_counter_q <= '0;
		end else if (accept) begin
			older_high_q  <= prior_high_q;
			older_low_q   <= prior_low_q;
			prior_high_q  <= bar_high;
			prior_low_q   <= bar_low;
			prior_close_q <= bar_close;
			if (bars_seen_q != 2'd2) bars_seen_q <= bars_seen_q + 2'd1;
			bar_counter_q <= bar_counter_q + NB'(1);
		end
	end

	// stage 1: bar plus history snapshot
	logic [P-1:0]  h_s1, l_s1, pc_s1, oh_s1, ol_s1;
	logic [1:0]    seen_s1;
	logic [NB-1:0] cnt_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			h_s1    <= bar_high;
			l_s1    <= bar_low;
			pc_s1   <= prior_close_q;
			oh_s1   <= older_high_q;
			ol_s1   <= older_low_q;
			seen_s1 <= bars_seen_q;
			cnt_s1  <= bar_counter_q;
		end
	end

	// true range and gap candidate
	logic [P-1:0] diff_hc, diff_lc, diff_hl, max_abs, tr_c, gap_c, bot_c, top_c;
	logic         up_c, dn_c;

	always_comb begin
		diff_hc = (h_s1 >= pc_s1) ? h_s1 - pc_s1 : pc_s1 - h_s1;
		diff_lc = (l_s1 >= pc_s1) ? l_s1 - pc_s1 : pc_s1 - l_s1;
		diff_hl = h_s1 - l_s1;
		max_abs = (diff_hc > diff_lc) ? diff_hc : diff_lc;
		tr_c    = (h_s1 >= l_s1 && diff_hl > max_abs) ? diff_hl : max_abs;
		up_c    = (seen_s1 == 2'd2) && (oh_s1 < l_s1);
		dn_c    = (seen_s1 == 2'd2) && (oh_s1 >= l_s1) && (ol_s1 > h_s1);
		gap_c   = up_c ? l_s1 - oh_s1 : ol_s1 - h_s1;
		bot_c   = up_c ? oh_s1 : h_s1;
		top_c   = up_c ? l_s1 : ol_s1;
	end

	// stage 2
	logic [P-1:0]  tr_s2, gap_s2, bot_s2, top_s2;
	logic          take_s2, cand_s2, down_s2;
	logic [NB-1:0] cnt_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			tr_s2   <= tr_c;
			gap_s2  <= gap_c;
			bot_s2  <= bot_c;
			top_s2  <= top_c;
			take_s2 <= (seen_s1 != 2'd0);
			cand_s2 <= up_c || dn_c;
			down_s2 <= !up_c;
			cnt_s2  <= cnt_s1;
		end
	end

	// true range ring and running sum
	logic [P-1:0]  range_ring [agpg_pkg::ATR_LEN];
	logic [PB-1:0] ring_ptr_q;
	logic [HB-1:0] held_q;
	logic [SB-1:0] range_sum_q, sum_next;
	logic [HB-1:0] held_next;
	logic          ring_full, ring_upd;

	always_comb begin
		ring_full = (held_q == HB'(agpg_pkg::ATR_LEN));
		ring_upd  = rdy3 && v_s2 && take_s2;
		sum_next  = range_sum_q + SB'(tr_s2)
			- (ring_full ? SB'(range_ring[ring_ptr_q]) : SB'(0));
		held_next = ring_full ? held_q : held_q + HB'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_ptr_q  <= '0;
			held_q      <= '0;
			range_sum_q <= '0;
		end else if (ring_upd) begin
			range_sum_q <= sum_next;
			held_q      <= held_next;
			if (ring_ptr_q == PB'(agpg_pkg::ATR_LEN - 1)) ring_ptr_q <= '0;
			else ring_ptr_q <= ring_ptr_q + PB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ring_upd) range_ring[ring_ptr_q] <= tr_s2;
	end

	// stage 3: gap with the updated sum and count
	logic [P-1:0]  gap_s3, bot_s3, top_s3;
	logic [SB-1:0] sum_s3;
	logic [HB-1:0] held_s3;
	logic          cand_s3, down_s3;
	logic [NB-1:0] cnt_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			gap_s3  <= gap_s2;
			bot_s3  <= bot_s2;
			top_s3  <= top_s2;
			sum_s3  <= take_s2 ? sum_next : range_sum_q;
			held_s3 <= take_s2 ? held_next : held_q;
			cand_s3 <= cand_s2;
			down_s3 <= down_s2;
			cnt_s3  <= cnt_s2;
		end
	end

	// stage 4: cross multiplies
	logic [LB-1:0] lhs_prod;
	logic [CB-1:0] lhs_s4, lo_s4, hi_s4;
	logic [P-1:0]  bot_s4, top_s4;
	logic          cand_s4, down_s4, nz_s4;
	logic [NB-1:0] cnt_s4;

	assign lhs_prod = LB'(gap_s3) * LB'(held_s3);

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			lhs_s4  <= CB'({lhs_prod, {agpg_pkg::Q_FRAC{1'b0}}});
			lo_s4   <= CB'(min_gap_q) * CB'(sum_s3);
			hi_s4   <= CB'(max_gap_q) * CB'(sum_s3);
			nz_s4   <= (sum_s3 != '0) && (held_s3 != '0);
			bot_s4  <= bot_s3;
			top_s4  <= top_s3;
			cand_s4 <= cand_s3;
			down_s4 <= down_s3;
			cnt_s4  <= cnt_s3;
		end
	end

	// result register
	logic          hit;
	logic          res_down_q;
	logic [P-1:0]  res_bot_q, res_top_q;
	logic [NB-1:0] res_cnt_q;

	assign hit = v_s4 && cand_s4 && nz_s4 && (lhs_s4 >= lo_s4) && (lhs_s4 <= hi_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_v_q <= 1'b0;
		else if (rdy5) res_v_q <= hit;
	end

	always_ff @(posedge clk) begin
		if (rdy5 && hit) begin
			res_down_q <= down_s4;
			res_bot_q  <= bot_s4;
			res_top_q  <= top_s4;
			res_cnt_q  <= cnt_s4;
		end
	end

	assign gap_valid  = res_v_q;
	assign gap_down   = res_down_q;
	assign gap_bottom = res_bot_q;
	assign gap_top    = res_top_q;
	assign bar_number = res_cnt_q;

	// checks
	a_gap_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		gap_valid |-> (gap_bottom < gap_top))
		else $error("reported gap has bottom not below top");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ring_ptr_q < PB'(agpg_pkg::ATR_LEN)) && (held_q <= HB'(agpg_pkg::ATR_LEN)))
		else $error("ring pointer or fill count out of range");

	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q == '0) |-> (range_sum_q == '0))
		else $error("range sum nonzero with empty ring");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		bar_stall |=> v_s1)
		else $error("first stage lost its bar while stalled");

	a_seen_sat: assert property (@(posedge clk) disable iff (!arst_n)
		($past(bars_seen_q) == 2'd2) |-> (bars_seen_q == 2'd2))
		else $error("warm-up count left saturation");

endmodule

`default_nettype wire
